FILE: hdl/prlt_pkg.sv
// Package: item types, codes and constants of the pending request latency tracker.
`default_nettype none

package prlt_pkg;

  typedef enum logic [1:0] {
    OP_SEND  = 2'd0,
    OP_ACK   = 2'd1,
    OP_CHECK = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_MATCHED  = 3'd2,
    ST_NO_MATCH = 3'd3,
    ST_CHECKED  = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  localparam logic [31:0] TIMEOUT_RESET = 32'd5000;
  localparam logic [3:0]  EXPIRED_MAX   = 4'd15;

  typedef struct packed {
    op_t         operation;
    logic [15:0] message_id;
    logic [7:0]  message_kind;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  slot_used;
    logic [31:0] measured_latency;
    logic [3:0]  expired_now;
    logic [31:0] total_messages;
    logic [31:0] success_total;
    logic [31:0] timeout_total;
    logic [31:0] least_latency;
    logic [31:0] greatest_latency;
    logic [31:0] latency_sum;
  } rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  kind;
    logic [31:0] sent_at;
  } entry_t;

endpackage

`default_nettype wire

FILE: hdl/prlt_if.sv
// Interfaces: request and result channels with valid/ready handshake.
`default_nettype none

interface prlt_req_if
  import prlt_pkg::*;
  ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface prlt_rsp_if
  import prlt_pkg::*;
  ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/prlt_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module prlt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/pending_request_latency_tracker_top.sv
// Top level: outstanding request table with timeout and latency statistics.
//
//  channel | dir | handshake          | carries
//  --------+-----+--------------------+------------------------------------------
//  req     | in  | valid/ready        | operation, message_id, message_kind, now_ms
//  rsp     | out | valid/ready        | status, slot, latency, counters, min/max
//  cfg     | in  | cfg_we, no wait    | timeout_limit_ms
//
//  Slots are scanned one per cycle through a single entry RAM port and one
//  shared subtractor. A send scans for the first free slot; an acknowledge
//  scans for a match, then updates statistics; a check scans every slot.
//  req is taken only when idle; a finished result waits in the output
//  register, the next item may start meanwhile, and the completion step
//  stalls while that register is still full.
//  Synchronous reset empties the table and zeroes the statistics.
`default_nettype none

module pending_request_latency_tracker_top
  import prlt_pkg::*;
#(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  prlt_req_if.sink         req,
  prlt_rsp_if.source       rsp,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND,
    S_ACK_SCAN,
    S_ACK_UPDATE,
    S_CHK_SCAN,
    S_DONE
  } state_t;

  state_t            state;
  req_t              cur;
  logic [31:0]       timeout_limit;
  logic [SLOT_COUNT-1:0] active;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_more;
  logic              ev_valid;
  logic [IDX_W-1:0]  ev_idx;
  status_t           status;
  logic [IDX_W-1:0]  slot;
  logic [31:0]       latency;
  logic [3:0]        expired;
  logic [31:0]       count_messages;
  logic [31:0]       count_success;
  logic [31:0]       count_timeout;
  logic [31:0]       min_seen;
  logic [31:0]       max_seen;
  logic [31:0]       sum_latency;
  logic              seeded;
  logic              out_valid;
  rsp_t              out_data;

  logic              ram_we;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic [31:0]       age;
  logic              ev_active;
  logic              ack_hit;
  logic              expire_hit;

  prlt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOT_COUNT)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_idx),
    .wdata (ram_wdata),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // shared subtractor: latency on acknowledge, age on check
  assign age        = cur.now_ms - ram_rdata.sent_at;
  assign ev_active  = ev_valid && active[ev_idx];
  assign ack_hit    = ev_active && (ram_rdata.id == cur.message_id)
                      && (ram_rdata.kind == cur.message_kind);
  assign expire_hit = ev_active && (age > timeout_limit);

  assign ram_we    = (state == S_SEND) && !active[rd_idx];
  assign ram_wdata = '{id: cur.message_id, kind: cur.message_kind, sent_at: cur.now_ms};

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      timeout_limit  <= TIMEOUT_RESET;
      active         <= '0;
      rd_more        <= 1'b0;
      ev_valid       <= 1'b0;
      count_messages <= '0;
      count_success  <= '0;
      count_timeout  <= '0;
      min_seen       <= '0;
      max_seen       <= '0;
      sum_latency    <= '0;
      seeded         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_limit <= cfg_data;
      end
      if (rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur      <= req.data;
            rd_idx   <= '0;
            rd_more  <= 1'b1;
            ev_valid <= 1'b0;
            slot     <= '0;
            latency  <= '0;
            expired  <= '0;
            case (req.data.operation)
              OP_SEND:  state <= S_SEND;
              OP_ACK:   state <= S_ACK_SCAN;
              OP_CHECK: state <= S_CHK_SCAN;
              default: begin
                count_messages <= '0;
                count_success  <= '0;
                count_timeout  <= '0;
                min_seen       <= '0;
                max_seen       <= '0;
                sum_latency    <= '0;
                seeded         <= 1'b0;
                status         <= ST_CLEARED;
                state          <= S_DONE;
              end
            endcase
          end
        end

        S_SEND: begin
          if (!active[rd_idx]) begin
            active[rd_idx] <= 1'b1;
            slot           <= rd_idx;
            status         <= ST_STORED;
            state          <= S_DONE;
          end else if (rd_idx == LAST) begin
            status <= ST_FULL;
            state  <= S_DONE;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end

        S_ACK_SCAN, S_CHK_SCAN: begin
          ev_valid <= rd_more;
          if (rd_more) begin
            ev_idx  <= rd_idx;
            rd_idx  <= rd_idx + 1'b1;
            rd_more <= (rd_idx != LAST);
          end
          if (state == S_ACK_SCAN) begin
            if (ack_hit) begin
              active[ev_idx] <= 1'b0;
              latency        <= age;
              slot           <= ev_idx;
              status         <= ST_MATCHED;
              state          <= S_ACK_UPDATE;
            end else if (ev_valid && ev_idx == LAST) begin
              status <= ST_NO_MATCH;
              state  <= S_DONE;
            end
          end else begin
            if (expire_hit) begin
              active[ev_idx] <= 1'b0;
              count_messages <= count_messages + 32'd1;
              count_timeout  <= count_timeout + 32'd1;
              if (expired != EXPIRED_MAX) begin
                expired <= expired + 4'd1;
              end
            end
            if (ev_valid && ev_idx == LAST) begin
              status <= ST_CHECKED;
              state  <= S_DONE;
            end
          end
        end

        S_ACK_UPDATE: begin
          ev_valid       <= 1'b0;
          count_messages <= count_messages + 32'd1;
          count_success  <= count_success + 32'd1;
          sum_latency    <= sum_latency + latency;
          seeded         <= 1'b1;
          if (!seeded || latency < min_seen) begin
            min_seen <= latency;
          end
          if (!seeded || latency > max_seen) begin
            max_seen <= latency;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          ev_valid <= 1'b0;
          if (!out_valid || rsp.ready) begin
            out_valid                 <= 1'b1;
            out_data.status           <= status;
            out_data.slot_used        <= 3'(slot);
            out_data.measured_latency <= latency;
            out_data.expired_now      <= expired;
            out_data.total_messages   <= count_messages;
            out_data.success_total    <= count_success;
            out_data.timeout_total    <= count_timeout;
            out_data.least_latency    <= min_seen;
            out_data.greatest_latency <= max_seen;
            out_data.latency_sum      <= sum_latency;
            state                     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while an item is still in work");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the completion step");

  a_unseeded_zero: assert property (@(posedge clk) disable iff (rst)
    !seeded |-> (min_seen == 32'd0) && (max_seen == 32'd0))
    else $error("min/max set without any success");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    seeded |-> min_seen <= max_seen)
    else $error("minimum latency above maximum");

endmodule

`default_nettype wire

FILE: verif/pending_request_latency_tracker_top_tb.sv
// Testbench: randomised traffic and scoreboard for the pending request latency tracker.
module pending_request_latency_tracker_top_tb;
  import prlt_pkg::*;

  localparam int SLOTS = 8;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_data;

  prlt_req_if req_ch ();
  prlt_rsp_if rsp_ch ();

  pending_request_latency_tracker_top #(.SLOT_COUNT(SLOTS)) dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // tracker state mirror
  logic        tbl_busy [SLOTS] = '{default: 1'b0};
  logic [15:0] tbl_id   [SLOTS];
  logic [7:0]  tbl_kind [SLOTS];
  logic [31:0] tbl_sent [SLOTS];
  logic [31:0] n_msgs = '0, n_ok = '0, n_tmo = '0;
  logic [31:0] lat_min = '0, lat_max = '0, lat_sum = '0;
  logic        lat_seeded = 1'b0;
  logic [31:0] limit_ms = TIMEOUT_RESET;

  req_t req_backlog [$];
  rsp_t due_results [$];
  int   items_issued = 0;
  int   items_taken = 0;
  int   results_seen = 0;
  int   mismatches = 0;
  int   cycles = 0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   hold_left = 0;
  int   ready_mode = 0;

  // generator shadow of the open requests
  entry_t      gen_open [$];
  logic [31:0] gen_now;

  function automatic rsp_t track_request(req_t it);
    rsp_t        r;
    logic [31:0] age;
    r = '0;
    case (it.operation)
      OP_SEND: begin
        r.status = ST_FULL;
        for (int s = 0; s < SLOTS; s++) begin
          if (!tbl_busy[s]) begin
            tbl_busy[s] = 1'b1;
            tbl_id[s]   = it.message_id;
            tbl_kind[s] = it.message_kind;
            tbl_sent[s] = it.now_ms;
            r.status    = ST_STORED;
            r.slot_used = s[2:0];
            break;
          end
        end
      end
      OP_ACK: begin
        r.status = ST_NO_MATCH;
        for (int s = 0; s < SLOTS; s++) begin
          if (tbl_busy[s] && tbl_id[s] == it.message_id && tbl_kind[s] == it.message_kind) begin
            age = it.now_ms - tbl_sent[s];
            n_msgs++;
            n_ok++;
            lat_sum += age;
            if (!lat_seeded) begin
              lat_min    = age;
              lat_max    = age;
              lat_seeded = 1'b1;
            end else begin
              if (age < lat_min) lat_min = age;
              if (age > lat_max) lat_max = age;
            end
            tbl_busy[s] = 1'b0;
            r.status = ST_MATCHED;
            r.slot_used = s[2:0];
            r.measured_latency = age;
            break;
          end
        end
      end
      OP_CHECK: begin
        r.status = ST_CHECKED;
        for (int s = 0; s < SLOTS; s++) begin
          age = it.now_ms - tbl_sent[s];
          if (tbl_busy[s] && age > limit_ms) begin
            n_msgs++;
            n_tmo++;
            tbl_busy[s] = 1'b0;
            if (r.expired_now < EXPIRED_MAX) r.expired_now++;
          end
        end
      end
      default: begin
        n_msgs = '0;
        n_ok = '0;
        n_tmo = '0;
        lat_min = '0;
        lat_max = '0;
        lat_sum = '0;
        lat_seeded = 1'b0;
        r.status = ST_CLEARED;
      end
    endcase
    r.total_messages   = n_msgs;
    r.success_total    = n_ok;
    r.timeout_total    = n_tmo;
    r.least_latency    = lat_min;
    r.greatest_latency = lat_max;
    r.latency_sum      = lat_sum;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic add_item(op_t op, logic [15:0] id, logic [7:0] kind, logic [31:0] now);
    req_t it;
    it.operation    = op;
    it.message_id   = id;
    it.message_kind = kind;
    it.now_ms       = now;
    req_backlog.push_back(it);
    items_issued++;
  endtask

  task automatic set_timeout(logic [31:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    limit_ms = v;
  endtask

  task automatic drain();
    while (items_taken != items_issued || due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(int n, int step_max, bit narrow);
    entry_t      e;
    int          pick;
    int          idx;
    logic [15:0] id;
    logic [7:0]  kind;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 5) gen_now = $urandom;
      else gen_now += $urandom_range(0, step_max);
      id   = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom);
      kind = narrow ? 8'($urandom_range(0, 1)) : 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        add_item(OP_SEND, id, kind, gen_now);
        if (gen_open.size() < SLOTS) begin
          e.id = id;
          e.kind = kind;
          e.sent_at = gen_now;
          gen_open.push_back(e);
        end
      end else if (pick < 75 && gen_open.size() > 0) begin
        idx = $urandom_range(0, gen_open.size() - 1);
        e = gen_open[idx];
        gen_open.delete(idx);
        add_item(OP_ACK, e.id, e.kind, gen_now);
      end else if (pick < 85) begin
        add_item(OP_ACK, id, kind, gen_now);
      end else if (pick < 98) begin
        add_item(OP_CHECK, id, kind, gen_now);
        for (int j = gen_open.size() - 1; j >= 0; j--)
          if (gen_now - gen_open[j].sent_at > limit_ms) gen_open.delete(j);
      end else begin
        add_item(OP_CLEAR, id, kind, gen_now);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_timeout(TIMEOUT_RESET);
    add_item(OP_ACK,   16'h0000, 8'h00, 32'd0);
    add_item(OP_CHECK, 16'h0000, 8'h00, 32'd100);
    add_item(OP_SEND,  16'hFFFF, 8'hFF, 32'hFFFF_FF00);
    add_item(OP_SEND,  16'h0000, 8'h00, 32'd0);
    add_item(OP_SEND,  16'h1234, 8'h05, 32'd10);
    add_item(OP_SEND,  16'h1234, 8'h05, 32'd20);
    add_item(OP_SEND,  16'hAAAA, 8'h55, 32'd30);
    add_item(OP_SEND,  16'h5555, 8'hAA, 32'd40);
    add_item(OP_SEND,  16'h0001, 8'h01, 32'd50);
    add_item(OP_SEND,  16'h8000, 8'h80, 32'd60);
    add_item(OP_SEND,  16'h7777, 8'h77, 32'd70);        // table full
    add_item(OP_ACK,   16'hFFFF, 8'hFF, 32'h0000_0100); // latency across the wrap
    add_item(OP_ACK,   16'h1234, 8'h05, 32'd1010);      // lowest of two duplicates
    add_item(OP_ACK,   16'h1234, 8'h06, 32'd1010);      // kind differs
    add_item(OP_ACK,   16'h0000, 8'h00, 32'd5000);
    add_item(OP_SEND,  16'h9999, 8'h09, 32'd5000);
    add_item(OP_CHECK, 16'h0000, 8'h00, 32'd5030);      // one at limit+10, one exactly at limit
    add_item(OP_CLEAR, 16'h0000, 8'h00, 32'd5030);
    add_item(OP_CHECK, 16'h0000, 8'h00, 32'd5031);      // timeout first after clear
    add_item(OP_ACK,   16'h5555, 8'hAA, 32'd5100);      // seeds min and max
    add_item(OP_ACK,   16'h0001, 8'h01, 32'd5060);
    add_item(OP_CHECK, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    add_item(OP_CLEAR, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    gen_now = 32'hFFFF_0000;
    random_phase(250, 3000, 1'b0);
    drain();

    set_timeout(32'd0);
    random_phase(220, 4, 1'b1);
    drain();
    set_timeout(32'hFFFF_FFFF);
    random_phase(220, 4000, 1'b1);
    drain();
    set_timeout(32'd37);
    random_phase(220, 60, 1'b0);
    drain();
    set_timeout($urandom);
    random_phase(220, 3000, 1'b0);
    drain();
    set_timeout($urandom_range(800, 20000));
    random_phase(220, 3000, 1'b1);
    drain();
    repeat (30) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    logic take;
    take = req_ch.valid && req_ch.ready;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (take) begin
        due_results.push_back(track_request(req_ch.data));
        items_taken++;
      end
      if (req_ch.valid && !take) begin
        req_ch.valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (req_backlog.size() > 0) begin
        req_ch.data  <= req_backlog.pop_front();
        req_ch.valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    rsp_t want;
    logic got;
    got = rsp_ch.valid && rsp_ch.ready;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (got) begin
        if (due_results.size() == 0) begin
          $error("result item with nothing outstanding");
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("status", 32'(want.status), 32'(rsp_ch.data.status));
          check_field("slot_used", 32'(want.slot_used), 32'(rsp_ch.data.slot_used));
          check_field("measured_latency", want.measured_latency,
                      rsp_ch.data.measured_latency);
          check_field("expired_now", 32'(want.expired_now), 32'(rsp_ch.data.expired_now));
          check_field("total_messages", want.total_messages, rsp_ch.data.total_messages);
          check_field("success_total", want.success_total, rsp_ch.data.success_total);
          check_field("timeout_total", want.timeout_total, rsp_ch.data.timeout_total);
          check_field("least_latency", want.least_latency, rsp_ch.data.least_latency);
          check_field("greatest_latency", want.greatest_latency,
                      rsp_ch.data.greatest_latency);
          check_field("latency_sum", want.latency_sum, rsp_ch.data.latency_sum);
        end
        results_seen++;
        if (results_seen == 150 || results_seen == 700) hold_left = 500;
      end
      if (cycles % 64 == 0) ready_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (ready_mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          2: rsp_ch.ready <= (cycles % 4 == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
